FILE: src/gtg_pkg.sv
// Shared types, constants and the arctangent table of the go-to-goal controller.
package gtg_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int IT_W = 5;
  localparam int CX_W = 24;
  localparam int CZ_W = 28;

  localparam logic signed [CZ_W-1:0] ANG_PI = 28'sd52707179;
  localparam logic [15:0] INV_GAIN = 16'd39797;
  localparam logic [17:0] LIN_MAX = 18'h3FFFF;

  localparam logic [1:0] REG_LIN_GAIN = 2'd0;
  localparam logic [1:0] REG_ANG_GAIN = 2'd1;
  localparam logic [1:0] REG_TOL = 2'd2;

  typedef struct packed {
    logic               is_goal;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic signed [14:0] hdg;
  } job_t;

  typedef struct packed {
    logic [15:0] lin_gain;
    logic [15:0] ang_gain;
    logic [15:0] tol;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic armed;
  } back_status_t;

  function automatic logic signed [CZ_W-1:0] atan_lut(input logic [IT_W-1:0] i);
    logic signed [CZ_W-1:0] v;
    unique case (i)
      5'd0: v = 28'sd13176795;
      5'd1: v = 28'sd7778716;
      5'd2: v = 28'sd4110060;
      5'd3: v = 28'sd2086331;
      5'd4: v = 28'sd1047214;
      5'd5: v = 28'sd524117;
      5'd6: v = 28'sd262123;
      5'd7: v = 28'sd131069;
      5'd8: v = 28'sd65536;
      5'd9: v = 28'sd32768;
      5'd10: v = 28'sd16384;
      5'd11: v = 28'sd8192;
      5'd12: v = 28'sd4096;
      5'd13: v = 28'sd2048;
      5'd14: v = 28'sd1024;
      5'd15: v = 28'sd512;
      5'd16: v = 28'sd256;
      5'd17: v = 28'sd128;
      5'd18: v = 28'sd64;
      5'd19: v = 28'sd32;
      5'd20: v = 28'sd16;
      5'd21: v = 28'sd8;
      5'd22: v = 28'sd4;
      5'd23: v = 28'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/gtg_front.sv
// Front end: accepts input items, keeps pose and target, forms goal-offset jobs.
module gtg_front import gtg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,
  input  logic        s_tuser,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  logic signed [15:0] last_x, last_y, target_x, target_y;
  logic signed [14:0] last_heading;
  logic signed [15:0] in_x, in_y;
  logic signed [14:0] in_h;
  logic               take;

  assign in_x = s_tdata[15:0];
  assign in_y = s_tdata[31:16];
  assign in_h = s_tdata[46:32];
  assign s_tready = job_ready;
  assign job_valid = s_tvalid;
  assign take = s_tvalid && job_ready;

  always_comb begin
    job.is_goal = s_tuser;
    if (s_tuser) begin
      job.dx  = 17'(in_x) - 17'(last_x);
      job.dy  = 17'(in_y) - 17'(last_y);
      job.hdg = last_heading;
    end else begin
      job.dx  = 17'(target_x) - 17'(in_x);
      job.dy  = 17'(target_y) - 17'(in_y);
      job.hdg = in_h;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_x <= '0;
      last_y <= '0;
      last_heading <= '0;
      target_x <= '0;
      target_y <= '0;
    end else if (take) begin
      if (s_tuser) begin
        target_x <= in_x;
        target_y <= in_y;
      end else begin
        last_x <= in_x;
        last_y <= in_y;
        last_heading <= in_h;
      end
    end
  end

endmodule

FILE: src/gtg_queue.sv
// Two-entry job queue between front and back.
module gtg_queue import gtg_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_job,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_job
);

  job_t       mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job = mem[rd_ptr];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: src/gtg_back.sv
// Back end: CORDIC vectoring, gain multiplies, arrival check and output register.
module gtg_back import gtg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         job_valid,
  output logic         job_ready,
  input  job_t         job,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [39:0]  m_tdata,
  output logic         m_tuser,
  output back_status_t status
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_MUL2 = 3'd3;
  localparam logic [2:0] ST_FIN = 3'd4;

  logic [2:0]             state;
  logic                   armed;
  logic [IT_W-1:0]        it;
  logic signed [CX_W-1:0] cx, cy;
  logic signed [CZ_W-1:0] cz;
  logic                   zero_vec, is_goal;
  logic signed [14:0]     hdg;
  logic [39:0]            prod_d;
  logic signed [16:0]     bear;
  logic [17:0]            dist_q;
  logic [33:0]            prod_l;
  logic signed [34:0]     prod_t;
  logic signed [CX_W-1:0] x0, y0, xs, ys;
  logic [40:0]            dist_full;
  logic signed [CZ_W-1:0] bear_full;
  logic signed [17:0]     err;
  logic [34:0]            lin_full;
  logic signed [35:0]     turn_full;
  logic [17:0]            lin_sat;
  logic signed [18:0]     turn_sat;
  logic                   slot_free;

  assign job_ready = (state == ST_IDLE);
  assign status.busy = (state != ST_IDLE);
  assign status.armed = armed;
  assign slot_free = !m_tvalid || m_tready;

  assign x0 = CX_W'(job.dx) <<< 4;
  assign y0 = CX_W'(job.dy) <<< 4;
  assign xs = cx >>> it;
  assign ys = cy >>> it;
  assign dist_full = {1'b0, prod_d} + 41'(20'h80000);
  assign bear_full = (cz + CZ_W'(2048)) >>> 12;
  assign err = 18'(bear) - 18'(hdg);
  assign lin_full = {1'b0, prod_l} + 35'd2048;
  assign turn_full = (36'(prod_t) + 36'sd2048) >>> 12;

  always_comb begin
    if (lin_full[34:12] > 23'(LIN_MAX)) lin_sat = LIN_MAX;
    else lin_sat = lin_full[29:12];
    if (turn_full > 36'sd262143) turn_sat = 19'sd262143;
    else if (turn_full < -36'sd262144) turn_sat = -19'sd262144;
    else turn_sat = turn_full[18:0];
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        it <= '0;
        is_goal <= job.is_goal;
        hdg <= job.hdg;
        zero_vec <= (job.dx == 17'sd0) && (job.dy == 17'sd0);
        if (job.dx < 0) begin
          cx <= -x0;
          cy <= -y0;
          cz <= (job.dy >= 0) ? ANG_PI : -ANG_PI;
        end else begin
          cx <= x0;
          cy <= y0;
          cz <= '0;
        end
      end
      ST_RUN: begin
        it <= it + 1'b1;
        if (cy >= 0) begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + atan_lut(it);
        end else begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - atan_lut(it);
        end
      end
      ST_MUL1: begin
        prod_d <= zero_vec ? '0 : 40'(unsigned'(cx)) * 40'(INV_GAIN);
        bear <= zero_vec ? '0 : bear_full[16:0];
      end
      ST_MUL2: begin
        dist_q <= dist_full[37:20];
        prod_l <= 34'(cfg.lin_gain) * 34'(dist_full[37:20]);
        prod_t <= 35'(signed'({1'b0, cfg.ang_gain})) * 35'(err);
      end
      ST_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && slot_free) begin
      if (!is_goal && dist_q <= 18'(cfg.tol)) begin
        m_tdata <= '0;
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= {3'b0, turn_sat, lin_sat};
        m_tuser <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      armed <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (job_valid && (job.is_goal || armed)) state <= ST_RUN;
        end
        ST_RUN: begin
          if (it == IT_W'(CORDIC_STEPS - 1)) state <= ST_MUL1;
        end
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_FIN;
        ST_FIN: begin
          if (slot_free) begin
            m_tvalid <= 1'b1;
            armed <= is_goal || (dist_q > 18'(cfg.tol));
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: src/go_to_goal_controller.sv
// Top level of the go-to-goal proportional controller.
// Steers a unicycle robot toward a goal point.
// Input stream s_*: s_tuser = 1 carries a new goal, 0 a pose sample.
//   A goal arms the controller and yields a command from the last pose.
//   A pose while armed yields a command, or one stop (m_tuser = 1) once the
//   distance is within arrive_tolerance, which disarms. A pose while idle
//   only updates the stored pose.
// Output stream m_*: linear speed and turn rate, saturated, zeros on stop.
// Config port: cfg_we/cfg_index/cfg_data; index 0 linear gain, 1 angular
//   gain, 2 arrive tolerance; other indexes are ignored.
// Path from input transfer to output valid: the queue register, the CORDIC
//   registers loaded in the idle state, the iterative CORDIC at one step per
//   cycle, the MUL1 and MUL2 multiply states and the FIN state that loads the
//   output register. One item is worked on at a time, so the back takes no new
//   job before it has finished the last; a two-entry queue lets the front take
//   items while the back runs.
// Reset (synchronous rst) restores default gains, clears pose, target and
//   armed state, and empties the queue and output register.
// While m_tready is low the result holds in the output register; the back
//   waits, the queue fills, then s_tready drops.
module go_to_goal_controller import gtg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // pos_x[15:0], pos_y[31:16], heading[46:32]
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // linear_speed[17:0], turn_rate[36:18]
  output logic        m_tuser,   // stopped
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t         cfg;
  job_t         f_job, q_job;
  logic         f_valid, f_ready, q_valid, q_ready;
  back_status_t bk_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lin_gain <= 16'd4096;
      cfg.ang_gain <= 16'd16384;
      cfg.tol <= 16'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LIN_GAIN: cfg.lin_gain <= cfg_data;
        REG_ANG_GAIN: cfg.ang_gain <= cfg_data;
        REG_TOL: cfg.tol <= cfg_data;
        default: ;
      endcase
    end
  end

  gtg_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  gtg_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_job(f_job),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_job(q_job)
  );

  gtg_back u_back (
    .clk, .rst, .cfg,
    .job_valid(q_valid), .job_ready(q_ready), .job(q_job),
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .status(bk_st)
  );

  // a stop command carries zero speed and turn rate
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("stop with nonzero command");

  // a pending stop means the controller is disarmed
  assert property (@(posedge clk) disable iff (rst) (m_tvalid && m_tuser) |-> !bk_st.armed)
    else $error("armed while stop pending");

  // the back only takes a job from the queue while idle
  assert property (@(posedge clk) disable iff (rst) (q_valid && q_ready) |-> !bk_st.busy)
    else $error("job popped while busy");

endmodule
